### hdl/register_slot_cache_assert.svh
// Assertion helpers for the register slot cache.
`ifndef REGISTER_SLOT_CACHE_ASSERT_SVH
`define REGISTER_SLOT_CACHE_ASSERT_SVH

`ifndef SYNTH
`define RSC_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define RSC_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define RSC_ASSERT(label, clk, rstn, prop, msg)
`define RSC_NEVER(label, clk, rstn, cond, msg)
`endif

`endif

### hdl/rsc_pkg.sv
package rsc_pkg;

    localparam int OPC_W     = 3;
    localparam int VM_REG_W  = 6;
    localparam int REL_W     = 2;
    localparam int SLOT_W    = 2;
    localparam int VM_REGS   = 1 << VM_REG_W;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 8;
    localparam int M_TUSER_W = 3;

    typedef enum logic [OPC_W-1:0] {
        OP_READ    = 3'd0,
        OP_WRITE   = 3'd1,
        OP_RMW     = 3'd2,
        OP_RELEASE = 3'd3,
        OP_SYNC    = 3'd4
    } op_t;

endpackage

### hdl/rsc_tag_store.sv
module rsc_tag_store #(
    parameter int NUM_SLOTS = 3,
    parameter int TAG_W     = 6,
    localparam int IDX_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  logic [TAG_W-1:0] wr_tag,
    input  logic [IDX_W-1:0] rd_idx,
    input  logic [TAG_W-1:0] cmp_tag,
    output logic [TAG_W-1:0] rd_tag,
    output logic             tag_match
);

    logic [TAG_W-1:0] tag_mem [NUM_SLOTS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            tag_mem[wr_idx] <= wr_tag;
        end
    end

    // single shared comparator, stepped across the slots by the sequencer
    assign rd_tag    = tag_mem[rd_idx];
    assign tag_match = (tag_mem[rd_idx] == cmp_tag);

endmodule

### hdl/register_slot_cache.sv
// Channel | Dir | tdata (low bit up)              | tuser (low bit up)          | tlast
// s_axis  | in  | vm_reg[5:0], release_slot[7:6]  | opcode[2:0]                 | -
// m_axis  | out | slot[1:0], writeback_reg[7:2]   | fail, writeback_valid, load | last_result
//
// Read/write/rmw: accepted in ST_IDLE, then a scan through the shared tag comparator up to a hit or the last slot.
// Sync: accepted in ST_IDLE, then one result per slot.
// Release and unused opcodes: accepted in ST_IDLE, no result.
// Reset clears all marks; tags are written before use. A stalled m_axis holds the scan once it has a result.
module register_slot_cache #(
    parameter int NUM_SLOTS       = 3,
    parameter int GUEST_REG_COUNT = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [rsc_pkg::S_TDATA_W-1:0] s_axis_tdata,  // vm_reg, release_slot
    input  logic [rsc_pkg::OPC_W-1:0]     s_axis_tuser,  // opcode
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [rsc_pkg::M_TDATA_W-1:0] m_axis_tdata,  // slot, writeback_reg
    output logic [rsc_pkg::M_TUSER_W-1:0] m_axis_tuser,  // fail, writeback_valid, load_valid
    output logic                          m_axis_tlast   // last_result
);
    import rsc_pkg::*;

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int TAG_W = $clog2(GUEST_REG_COUNT);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

    typedef logic [TAG_W-1:0] mod_tab_t [VM_REGS];

    function automatic mod_tab_t mod_table();
        mod_tab_t t;
        for (int i = 0; i < VM_REGS; i++) begin
            t[i] = TAG_W'(i % GUEST_REG_COUNT);
        end
        return t;
    endfunction

    localparam mod_tab_t REG_MOD = mod_table();

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SYNC
    } state_t;

    state_t               state_reg;
    op_t                  op_reg;
    logic [TAG_W-1:0]     vreg_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic                 free_found_reg;
    logic [IDX_W-1:0]     free_idx_reg;
    logic                 free_wbv_reg;
    logic [TAG_W-1:0]     free_wbr_reg;
    logic [NUM_SLOTS-1:0] valid_reg;
    logic [NUM_SLOTS-1:0] dirty_reg;
    logic [NUM_SLOTS-1:0] pinned_reg;

    logic                 m_tvalid_reg;
    logic [SLOT_W-1:0]    out_slot_reg;
    logic                 out_fail_reg;
    logic                 out_wbv_reg;
    logic [VM_REG_W-1:0]  out_wbr_reg;
    logic                 out_load_reg;
    logic                 out_last_reg;

    op_t                  in_op;
    logic [VM_REG_W-1:0]  in_vm_reg;
    logic [REL_W-1:0]     in_rel;
    logic [NUM_SLOTS-1:0] rel_mask;

    logic [TAG_W-1:0]     rd_tag;
    logic                 tag_match;
    logic                 tag_wr;

    logic                 cur_valid;
    logic                 cur_dirty;
    logic                 cur_pin;
    logic                 scan_hit;
    logic                 scan_last;
    logic                 scan_done;
    logic                 victim_found;
    logic [IDX_W-1:0]     victim_idx;
    logic                 victim_wbv;
    logic [TAG_W-1:0]     victim_wbr;
    logic                 out_free;
    logic                 emit;

    logic [SLOT_W-1:0]         res_slot;
    logic                      res_fail;
    logic                      res_wbv;
    logic [TAG_W-1:0]          res_wbr;
    logic                      res_load;
    logic                      res_last;
    logic [IDX_W+SLOT_W-1:0]   slot_ext;
    logic [IDX_W-1:0]          res_idx;
    logic [TAG_W+VM_REG_W-1:0] wbr_ext;

    assign in_op     = op_t'(s_axis_tuser);
    assign in_vm_reg = s_axis_tdata[VM_REG_W-1:0];
    assign in_rel    = s_axis_tdata[VM_REG_W +: REL_W];

    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            rel_mask[i] = (int'(in_rel) == i);
        end
    end

    rsc_tag_store #(
        .NUM_SLOTS(NUM_SLOTS),
        .TAG_W    (TAG_W)
    ) u_tag_store (
        .aclk     (aclk),
        .wr_en    (tag_wr),
        .wr_idx   (victim_idx),
        .wr_tag   (vreg_reg),
        .rd_idx   (idx_reg),
        .cmp_tag  (vreg_reg),
        .rd_tag   (rd_tag),
        .tag_match(tag_match)
    );

    assign cur_valid    = valid_reg[idx_reg];
    assign cur_dirty    = dirty_reg[idx_reg];
    assign cur_pin      = pinned_reg[idx_reg];
    assign scan_hit     = cur_valid && tag_match;
    assign scan_last    = (idx_reg == LAST_IDX);
    assign scan_done    = (state_reg == ST_SCAN) && (scan_hit || scan_last);
    assign victim_found = free_found_reg || !cur_pin;
    assign victim_idx   = free_found_reg ? free_idx_reg : idx_reg;
    assign victim_wbv   = free_found_reg ? free_wbv_reg : (cur_valid && cur_dirty);
    assign victim_wbr   = free_found_reg ? free_wbr_reg : rd_tag;
    assign out_free     = !m_tvalid_reg || m_axis_tready;
    assign emit         = (scan_done || (state_reg == ST_SYNC)) && out_free;
    assign tag_wr       = (state_reg == ST_SCAN) && emit && !scan_hit && victim_found;

    always_comb begin
        res_idx  = idx_reg;
        res_fail = 1'b0;
        res_wbv  = 1'b0;
        res_wbr  = '0;
        res_load = 1'b0;
        res_last = 1'b1;
        if (state_reg == ST_SYNC) begin
            res_wbv  = cur_valid && cur_dirty;
            res_wbr  = res_wbv ? rd_tag : '0;
            res_last = scan_last;
        end else if (!scan_hit) begin
            if (victim_found) begin
                res_idx  = victim_idx;
                res_wbv  = victim_wbv;
                res_wbr  = victim_wbv ? victim_wbr : '0;
                res_load = (op_reg != OP_WRITE);
            end else begin
                res_idx  = '0;
                res_fail = 1'b1;
            end
        end
        slot_ext = {{SLOT_W{1'b0}}, res_idx};
        res_slot = slot_ext[SLOT_W-1:0];
        wbr_ext  = {{VM_REG_W{1'b0}}, res_wbr};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            free_found_reg <= 1'b0;
            valid_reg      <= '0;
            dirty_reg      <= '0;
            pinned_reg     <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (emit) begin
                m_tvalid_reg <= 1'b1;
                out_slot_reg <= res_slot;
                out_fail_reg <= res_fail;
                out_wbv_reg  <= res_wbv;
                out_wbr_reg  <= wbr_ext[VM_REG_W-1:0];
                out_load_reg <= res_load;
                out_last_reg <= res_last;
            end else if (m_axis_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        idx_reg        <= '0;
                        free_found_reg <= 1'b0;
                        op_reg         <= in_op;
                        vreg_reg       <= REG_MOD[in_vm_reg];
                        unique case (in_op)
                            OP_READ, OP_WRITE, OP_RMW: begin
                                state_reg <= ST_SCAN;
                            end
                            OP_RELEASE: begin
                                pinned_reg <= pinned_reg & ~rel_mask;
                            end
                            OP_SYNC: begin
                                state_reg <= ST_SYNC;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (emit) begin
                        state_reg <= ST_IDLE;
                        if (scan_hit) begin
                            pinned_reg[idx_reg] <= 1'b1;
                            if (op_reg != OP_READ) begin
                                dirty_reg[idx_reg] <= 1'b1;
                            end
                        end else if (victim_found) begin
                            valid_reg[victim_idx]  <= 1'b1;
                            pinned_reg[victim_idx] <= 1'b1;
                            dirty_reg[victim_idx]  <= (op_reg != OP_READ);
                        end
                    end else if (!scan_done) begin
                        idx_reg <= idx_reg + 1'b1;
                        if (!cur_pin && !free_found_reg) begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= idx_reg;
                            free_wbv_reg   <= cur_valid && cur_dirty;
                            free_wbr_reg   <= rd_tag;
                        end
                    end
                end
                ST_SYNC: begin
                    if (emit) begin
                        if (scan_last) begin
                            state_reg  <= ST_IDLE;
                            valid_reg  <= '0;
                            dirty_reg  <= '0;
                            pinned_reg <= '0;
                        end else begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = {out_wbr_reg, out_slot_reg};
    assign m_axis_tuser  = {out_load_reg, out_wbv_reg, out_fail_reg};
    assign m_axis_tlast  = out_last_reg;

`include "register_slot_cache_assert.svh"

    `RSC_NEVER(a_pin_needs_valid, aclk, aresetn, (pinned_reg & ~valid_reg) != '0, "pinned slot not valid")
    `RSC_NEVER(a_dirty_needs_valid, aclk, aresetn, (dirty_reg & ~valid_reg) != '0, "dirty slot not valid")
    `RSC_ASSERT(a_fail_all_pinned, aclk, aresetn, (emit && res_fail) |-> (&pinned_reg), "fail with free slot")
    `RSC_ASSERT(a_sync_clears, aclk, aresetn, (emit && state_reg == ST_SYNC && res_last) |=> (valid_reg == '0), "sync left marks")

endmodule

### sim/tb.sv
`timescale 1ns / 100ps

module tb;
    import rsc_pkg::*;

    localparam int NUM_SLOTS       = 3;
    localparam int GUEST_REG_COUNT = 64;
    localparam int STUCK_LIMIT     = 2000;

    localparam logic [OPC_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OPC_W-1:0] OP_SPARE_MID   = 3'd6;
    localparam logic [OPC_W-1:0] OP_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic                fail;
        logic                wb_valid;
        logic [VM_REG_W-1:0] wb_reg;
        logic                load;
        logic                last;
    } grant_t;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;  // vm_reg[5:0], release_slot[7:6]
    logic [OPC_W-1:0]     s_axis_tuser  = '0;  // opcode
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;        // slot[1:0], writeback_reg[7:2]
    logic [M_TUSER_W-1:0] m_axis_tuser;        // fail, writeback_valid, load_valid
    logic                 m_axis_tlast;        // last_result

    // shadow copy of the slot marks and tags
    logic [NUM_SLOTS-1:0] slot_valid  = '0;
    logic [NUM_SLOTS-1:0] slot_dirty  = '0;
    logic [NUM_SLOTS-1:0] slot_pinned = '0;
    logic [VM_REG_W-1:0]  slot_tag [NUM_SLOTS];

    grant_t pending_grants [$];

    int src_idle_pct  = 0;
    int sink_stall_pct = 0;
    int hold_left     = 0;
    int errors        = 0;
    int requests_sent = 0;
    int grants_seen   = 0;
    int fails_seen    = 0;
    int writebacks    = 0;
    int stuck_cycles  = 0;

    register_slot_cache #(
        .NUM_SLOTS       (NUM_SLOTS),
        .GUEST_REG_COUNT (GUEST_REG_COUNT)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic update_slots(input logic [OPC_W-1:0] op, input logic [VM_REG_W-1:0] vreg,
                                input logic [REL_W-1:0] rel);
        grant_t g;
        bit     done;
        g    = '0;
        done = 1'b0;
        case (op)
            OP_READ, OP_WRITE, OP_RMW: begin
                g.last = 1'b1;
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (!done && slot_valid[i] && slot_tag[i] == vreg) begin
                        slot_pinned[i] = 1'b1;
                        if (op != OP_READ)
                            slot_dirty[i] = 1'b1;
                        g.slot = SLOT_W'(i);
                        done   = 1'b1;
                    end
                end
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (!done && !slot_pinned[i]) begin
                        if (slot_valid[i] && slot_dirty[i]) begin
                            g.wb_valid = 1'b1;
                            g.wb_reg   = slot_tag[i];
                        end
                        slot_valid[i]  = 1'b1;
                        slot_pinned[i] = 1'b1;
                        slot_tag[i]    = vreg;
                        slot_dirty[i]  = (op != OP_READ);
                        g.load = (op != OP_WRITE);
                        g.slot = SLOT_W'(i);
                        done   = 1'b1;
                    end
                end
                if (!done)
                    g.fail = 1'b1;
                pending_grants.push_back(g);
            end
            OP_RELEASE: begin
                if (rel < NUM_SLOTS)
                    slot_pinned[rel] = 1'b0;
            end
            OP_SYNC: begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    g = '0;
                    g.slot = SLOT_W'(i);
                    if (slot_valid[i] && slot_dirty[i]) begin
                        g.wb_valid = 1'b1;
                        g.wb_reg   = slot_tag[i];
                    end
                    g.last = (i == NUM_SLOTS - 1);
                    pending_grants.push_back(g);
                end
                slot_valid  = '0;
                slot_dirty  = '0;
                slot_pinned = '0;
            end
            default: ;
        endcase
    endtask

    task automatic send_op(input logic [OPC_W-1:0] op, input logic [VM_REG_W-1:0] vreg,
                           input logic [REL_W-1:0] rel);
        if ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {rel, vreg};
        s_axis_tuser  <= op;
        do @(posedge aclk); while (!s_axis_tready);
        update_slots(op, vreg, rel);
        requests_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_grants.size() != 0)
            @(posedge aclk);
    endtask

    task automatic send_random();
        logic [OPC_W-1:0]    op;
        logic [VM_REG_W-1:0] vreg;
        int                  pick;
        pick = $urandom_range(99);
        if (pick < 24)      op = OP_READ;
        else if (pick < 44) op = OP_WRITE;
        else if (pick < 60) op = OP_RMW;
        else if (pick < 88) op = OP_RELEASE;
        else if (pick < 94) op = OP_SYNC;
        else                op = OPC_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
        // mostly a small working set so that hits and evictions both happen
        vreg = $urandom_range(3) != 0 ? VM_REG_W'($urandom_range(7))
                                      : VM_REG_W'($urandom_range(GUEST_REG_COUNT - 1));
        send_op(op, vreg, REL_W'($urandom_range(3)));
    endtask

    task automatic test_directed_cases();
        send_op(OP_SYNC, 6'd0, 2'd0);
        send_op(OP_READ, 6'd0, 2'd3);
        send_op(OP_WRITE, 6'd63, 2'd0);
        send_op(OP_RMW, 6'd21, 2'd1);
        send_op(OP_READ, 6'd0, 2'd2);
        send_op(OP_READ, 6'd5, 2'd0);     // all pinned
        send_op(OP_RELEASE, 6'd63, 2'd3); // no such slot
        send_op(OP_WRITE, 6'd5, 2'd0);
        send_op(OP_RELEASE, 6'd0, 2'd1);
        send_op(OP_WRITE, 6'd5, 2'd0);    // evicts dirty 63
        send_op(OP_RELEASE, 6'd0, 2'd0);
        send_op(OP_RELEASE, 6'd0, 2'd2);
        send_op(OP_RMW, 6'd42, 2'd3);
        send_op(OP_SPARE_FIRST, 6'd63, 2'd3);
        send_op(OP_SPARE_MID, 6'd0, 2'd0);
        send_op(OP_SPARE_LAST, 6'd63, 2'd3);
        send_op(OP_WRITE, 6'd21, 2'd0);   // hits 21 in released slot 2
        send_op(OP_READ, 6'd5, 2'd0);
        send_op(OP_SYNC, 6'd0, 2'd0);
        send_op(OP_READ, 6'd63, 2'd3);
        send_op(OP_RELEASE, 6'd0, 2'd0);
        send_op(OP_SYNC, 6'd63, 2'd3);
        drain();
    endtask

    task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        repeat (count)
            send_random();
        drain();
    endtask

    task automatic test_output_stall();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_left      = 150;
        repeat (20)
            send_random();
        drain();
    endtask

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        grant_t want;
        grant_t got;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.slot     = m_axis_tdata[1:0];
            got.wb_reg   = m_axis_tdata[7:2];
            got.fail     = m_axis_tuser[0];
            got.wb_valid = m_axis_tuser[1];
            got.load     = m_axis_tuser[2];
            got.last     = m_axis_tlast;
            grants_seen++;
            fails_seen += got.fail;
            writebacks += got.wb_valid;
            if (pending_grants.size() == 0) begin
                $display("%0t unexpected result: got %p", $time, got);
                errors++;
            end else begin
                want = pending_grants.pop_front();
                if (got.slot != want.slot) begin
                    $display("%0t slot: exp %0d got %0d", $time, want.slot, got.slot);
                    errors++;
                end
                if (got.fail != want.fail) begin
                    $display("%0t fail: exp %0d got %0d", $time, want.fail, got.fail);
                    errors++;
                end
                if (got.wb_valid != want.wb_valid) begin
                    $display("%0t writeback_valid: exp %0d got %0d", $time, want.wb_valid,
                             got.wb_valid);
                    errors++;
                end
                if (got.wb_reg != want.wb_reg) begin
                    $display("%0t writeback_reg: exp %0d got %0d", $time, want.wb_reg,
                             got.wb_reg);
                    errors++;
                end
                if (got.load != want.load) begin
                    $display("%0t load_valid: exp %0d got %0d", $time, want.load, got.load);
                    errors++;
                end
                if (got.last != want.last) begin
                    $display("%0t last_result: exp %0d got %0d", $time, want.last, got.last);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t timeout, %0d results outstanding", $time, pending_grants.size());
            $display("tb: errors");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        test_random_traffic(50, 0, 0);
        test_random_traffic(50, 75, 0);
        test_random_traffic(50, 0, 75);
        test_random_traffic(50, 19, 19);
        test_output_stall();
        repeat (10) @(posedge aclk);
        $display("tb: %0d requests sent, %0d results checked", requests_sent, grants_seen);
        $display("tb: %0d pinned-out failures, %0d writebacks seen", fails_seen, writebacks);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/rsc_pkg.sv
hdl/rsc_tag_store.sv
hdl/register_slot_cache.sv
sim/tb.sv
